// File: rtl/vector_stroke_char_generator_defines.svh
// Assertion macros for the vector stroke character generator.
// Included by the modules that carry concurrent assertions; needs no other file.
`ifndef VECTOR_STROKE_CHAR_GENERATOR_DEFINES_SVH
`define VECTOR_STROKE_CHAR_GENERATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define VSCG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define VSCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/vscg_pkg.sv
// Types, codes, glyph table and grid helpers for the vector stroke character generator.
// Used by the top level; depends on nothing else.
package vscg_pkg;

   localparam int GLYPH_ENTRIES_DEFAULT = 256;

   localparam logic [7:0] LINE_FEED_CODE = 8'd10;
   localparam logic       KIND_MOVE      = 1'b0;
   localparam logic       KIND_LINE      = 1'b1;
   localparam logic       REG_STEP_X     = 1'b0;
   localparam logic       REG_STEP_Y     = 1'b1;
   localparam logic [7:0] STEP_RESET     = 8'd4;
   localparam logic [3:0] POS_END        = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_ADVANCE,
      ST_LFEED
   } vscg_state_type;

   typedef struct packed {
      logic [7:0]         char_code;
      logic               string_start;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
   } vscg_req_type;

   typedef struct packed {
      logic               stroke_kind;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic               last;
   } vscg_rsp_type;

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [3:0] nib;
      logic [3:0] next_pos;
   } vscg_stroke_type;

   function automatic logic [31:0] glyph_word(input logic [7:0] code);
      logic [31:0] w;
      case (code)
         8'd33: w = 32'h0002508E;
         8'd34: w = 32'h0008E07D;
         8'd37: w = 32'h360AD01F;
         8'd38: w = 32'h0003DF12;
         8'd39: w = 32'h000000BE;
         8'd40: w = 32'h000035BF;
         8'd41: w = 32'h000015BD;
         8'd42: w = 32'h6A04C097;
         8'd43: w = 32'h0009705B;
         8'd44: w = 32'h00000015;
         8'd45: w = 32'h00000097;
         8'd46: w = 32'h00000025;
         8'd47: w = 32'h0000001F;
         8'd48: w = 32'h000D13FD;
         8'd49: w = 32'h0000002E;
         8'd50: w = 32'h003179FD;
         8'd51: w = 32'h079013FD;
         8'd52: w = 32'h0028064D;
         8'd53: w = 32'h001397DF;
         8'd54: w = 32'h007931DF;
         8'd55: w = 32'h000001FD;
         8'd56: w = 32'h09713FD1;
         8'd57: w = 32'h0013FD79;
         8'd58: w = 32'h0002508B;
         8'd59: w = 32'h0001508B;
         8'd60: w = 32'h0000037F;
         8'd61: w = 32'h00064097;
         8'd62: w = 32'h0000019D;
         8'd63: w = 32'h31058CEA;
         8'd64: w = 32'h31DF6589;
         8'd65, 8'd97:  w = 32'h00793FD1;
         8'd66, 8'd98:  w = 32'hDFC7931D;
         8'd67, 8'd99:  w = 32'h000031DF;
         8'd68, 8'd100: w = 32'h000D13CD;
         8'd69, 8'd101: w = 32'h097031DF;
         8'd70, 8'd102: w = 32'h009701DF;
         8'd71, 8'd103: w = 32'h00FD1398;
         8'd72, 8'd104: w = 32'h003F971D;
         8'd73, 8'd105: w = 32'h0000002E;
         8'd74, 8'd106: w = 32'h0000F314;
         8'd75, 8'd107: w = 32'h0037F01D;
         8'd76, 8'd108: w = 32'h0000031D;
         8'd77, 8'd109: w = 32'h0003FBD1;
         8'd78, 8'd110: w = 32'h0000F3D1;
         8'd79, 8'd111: w = 32'h000D13FD;
         8'd80, 8'd112: w = 32'h0001DF97;
         8'd81, 8'd113: w = 32'h35013FD1;
         8'd82, 8'd114: w = 32'h00379FD1;
         8'd83, 8'd115: w = 32'h00426AEC;
         8'd84, 8'd116: w = 32'h0002E0FD;
         8'd85, 8'd117: w = 32'h0000F31D;
         8'd86, 8'd118: w = 32'h00000F2D;
         8'd87, 8'd119: w = 32'h000F351D;
         8'd88, 8'd120: w = 32'h000F103D;
         8'd89, 8'd121: w = 32'h0000D8F1;
         8'd90, 8'd122: w = 32'h000031FD;
         default: w = 32'h00000000;
      endcase
      return w;
   endfunction

   function automatic logic [1:0] grid_col(input logic [3:0] nib);
      logic [1:0] c;
      case (nib)
         4'd1, 4'd4, 4'd7, 4'd10, 4'd13: c = 2'd0;
         4'd2, 4'd5, 4'd8, 4'd11, 4'd14: c = 2'd1;
         4'd3, 4'd6, 4'd9, 4'd12, 4'd15: c = 2'd2;
         default: c = 2'd3;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] grid_row(input logic [3:0] nib);
      logic [2:0] r;
      case (nib)
         4'd4, 4'd5, 4'd6:    r = 3'd1;
         4'd7, 4'd8, 4'd9:    r = 3'd2;
         4'd10, 4'd11, 4'd12: r = 3'd3;
         4'd13, 4'd14, 4'd15: r = 3'd4;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   // Finds the stroke that starts at nibble position pos of a glyph word.
   function automatic vscg_stroke_type next_stroke(input logic [31:0] word,
                                                   input logic [3:0]  pos);
      vscg_stroke_type s;
      logic [2:0]      idx;
      logic [2:0]      idx_nxt;
      logic [3:0]      nib;
      logic [3:0]      nib_nxt;
      idx     = pos[2:0];
      idx_nxt = pos[2:0] + 3'd1;
      nib     = word[{idx, 2'b00} +: 4];
      nib_nxt = word[{idx_nxt, 2'b00} +: 4];
      s       = '0;
      if (pos == 4'd0) begin
         s.valid    = 1'b1;
         s.kind     = KIND_MOVE;
         s.nib      = word[3:0];
         s.next_pos = 4'd1;
      end else if (pos < POS_END) begin
         if (nib != 4'd0) begin
            s.valid    = 1'b1;
            s.kind     = KIND_LINE;
            s.nib      = nib;
            s.next_pos = pos + 4'd1;
         end else if (pos != 4'd7 && nib_nxt != 4'd0) begin
            s.valid    = 1'b1;
            s.kind     = KIND_MOVE;
            s.nib      = nib_nxt;
            s.next_pos = pos + 4'd2;
         end
      end
      return s;
   endfunction

   // Adds a small signed offset to a 16-bit coordinate and clamps the result.
   function automatic logic signed [15:0] sat_add(input logic signed [15:0] base,
                                                  input logic signed [11:0] off);
      logic signed [16:0] sum;
      logic signed [15:0] r;
      sum = 17'(base) + 17'(off);
      if (sum[16] != sum[15]) begin
         r = sum[16] ? 16'sh8000 : 16'sh7FFF;
      end else begin
         r = sum[15:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/vector_stroke_char_generator.sv
// A character is accepted only while idle; its strokes then go to the result register in turn,
// followed by the cursor advance, and a line feed moves the cursor to the next line start.
// One saturating x/y adder pair does every coordinate step.
// Result stalls hold the stroke sequencer. Synchronous reset clears the cursor and line start
// to zero, sets both step registers to 4 and leaves the block idle with no result pending.
module vector_stroke_char_generator
   import vscg_pkg::*;
#(
   parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  vscg_req_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output vscg_rsp_type rsp_item,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

`include "vector_stroke_char_generator_defines.svh"

   vscg_state_type     state_ff, state_in;
   logic [7:0]         step_x_ff, step_x_in;
   logic [7:0]         step_y_ff, step_y_in;
   logic signed [15:0] cursor_x_ff, cursor_x_in;
   logic signed [15:0] cursor_y_ff, cursor_y_in;
   logic signed [15:0] line_start_x_ff, line_start_x_in;
   logic signed [15:0] line_start_y_ff, line_start_y_in;
   logic [31:0]        word_ff, word_in;
   logic [3:0]         pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   vscg_rsp_type       rsp_item_ff, rsp_item_in;

   logic               req_accept;
   logic               cfg_write;
   logic               out_load;
   logic               stroke_last;
   vscg_stroke_type    cur_stroke;
   vscg_stroke_type    look_stroke;
   logic [9:0]         col_mul;
   logic [10:0]        row_mul;
   logic [9:0]         three_x;
   logic [10:0]        five_y;
   logic signed [15:0] unit_base_x, unit_base_y;
   logic signed [11:0] unit_off_x, unit_off_y;
   logic signed [15:0] unit_sum_x, unit_sum_y;

   assign pready     = 1'b1;
   assign cfg_write  = psel & penable & pwrite & pready;
   assign prdata     = (paddr[2] == REG_STEP_Y) ? {24'd0, step_y_ff} : {24'd0, step_x_ff};
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   assign cur_stroke  = next_stroke(word_ff, pos_ff);
   assign look_stroke = next_stroke(word_ff, cur_stroke.next_pos);
   assign stroke_last = ~look_stroke.valid;

   assign col_mul = 10'(grid_col(cur_stroke.nib)) * 10'(step_x_ff);
   assign row_mul = 11'(grid_row(cur_stroke.nib)) * 11'(step_y_ff);
   assign three_x = 10'(step_x_ff) * 10'd3;
   assign five_y  = 11'(step_y_ff) * 11'd5;

   always_comb begin
      case (state_ff)
         ST_EMIT: begin
            unit_base_x = cursor_x_ff;
            unit_off_x  = $signed({2'b00, col_mul});
            unit_base_y = cursor_y_ff;
            unit_off_y  = $signed({1'b0, row_mul});
         end
         ST_ADVANCE: begin
            unit_base_x = cursor_x_ff;
            unit_off_x  = $signed({2'b00, three_x});
            unit_base_y = cursor_y_ff;
            unit_off_y  = '0;
         end
         ST_LFEED: begin
            unit_base_x = line_start_x_ff;
            unit_off_x  = '0;
            unit_base_y = line_start_y_ff;
            unit_off_y  = -$signed({1'b0, five_y});
         end
         default: begin
            unit_base_x = cursor_x_ff;
            unit_off_x  = '0;
            unit_base_y = cursor_y_ff;
            unit_off_y  = '0;
         end
      endcase
   end

   assign unit_sum_x = sat_add(unit_base_x, unit_off_x);
   assign unit_sum_y = sat_add(unit_base_y, unit_off_y);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_item.char_code == LINE_FEED_CODE) ? ST_LFEED : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load && stroke_last) begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: state_in = ST_IDLE;
         ST_LFEED:   state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      out_load        = (state_ff == ST_EMIT) && (~rsp_valid_ff || ~rsp_stall);
      step_x_in       = step_x_ff;
      step_y_in       = step_y_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      line_start_x_in = line_start_x_ff;
      line_start_y_in = line_start_y_ff;
      word_in         = word_ff;
      pos_in          = pos_ff;
      rsp_item_in     = rsp_item_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;

      if (cfg_write) begin
         if (paddr[2] == REG_STEP_X) begin
            step_x_in = pwdata[7:0];
         end else begin
            step_y_in = pwdata[7:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_item.string_start) begin
                  cursor_x_in     = req_item.origin_x;
                  cursor_y_in     = req_item.origin_y;
                  line_start_x_in = req_item.origin_x;
                  line_start_y_in = req_item.origin_y;
               end
               word_in = (int'(req_item.char_code) < GLYPH_ENTRIES) ?
                         glyph_word(req_item.char_code) : 32'd0;
               pos_in  = 4'd0;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.stroke_kind = cur_stroke.kind;
               rsp_item_in.point_x     = unit_sum_x;
               rsp_item_in.point_y     = unit_sum_y;
               rsp_item_in.last        = stroke_last;
               pos_in                  = cur_stroke.next_pos;
            end
         end
         ST_ADVANCE: begin
            cursor_x_in = unit_sum_x;
         end
         ST_LFEED: begin
            line_start_y_in = unit_sum_y;
            cursor_x_in     = unit_sum_x;
            cursor_y_in     = unit_sum_y;
         end
         default: begin
            pos_in = 4'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_x_ff       <= STEP_RESET;
         step_y_ff       <= STEP_RESET;
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         line_start_x_ff <= '0;
         line_start_y_ff <= '0;
         pos_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         step_x_ff       <= step_x_in;
         step_y_ff       <= step_y_in;
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         line_start_x_ff <= line_start_x_in;
         line_start_y_ff <= line_start_y_in;
         pos_ff          <= pos_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rsp_item_ff <= rsp_item_in;
   end

   `VSCG_ASSERT_NEXT(a_last_then_advance, clock, reset, out_load && stroke_last,
                     state_ff == ST_ADVANCE, "last stroke not followed by cursor advance")
   `VSCG_ASSERT_SAME(a_pos_in_range, clock, reset, state_ff == ST_EMIT,
                     pos_ff <= POS_END, "nibble position past end of glyph word")
   `VSCG_ASSERT_SAME(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff),
                     $past(state_ff) == ST_EMIT, "result item appeared outside stroke emission")
   `VSCG_ASSERT_NEXT(a_lfeed_cursor, clock, reset, state_ff == ST_LFEED,
                     cursor_x_ff == line_start_x_ff && cursor_y_ff == line_start_y_ff,
                     "line feed did not return cursor to line start")

endmodule
